FILE: rtl/core/btfc_pkg.sv
`default_nettype none

package btfc_pkg;

    localparam int MAX_DIGITS_DEF = 24;
    localparam int RESULT_CAP     = 24;
    localparam int CNT_W          = $clog2(RESULT_CAP + 1);

    // Enough balanced ternary digits for a magnitude of 2^31
    localparam int DIG_DEPTH = 21;
    localparam int DIG_W     = $clog2(DIG_DEPTH);

    // Largest point shift a 31-bit denominator can give
    localparam int MOV_MAX = 19;

    // ceil(2^33 / 3): floor(y / 3) == (y * RECIP3) >> 33 for any 32-bit y
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    localparam logic [1:0] SYM_ZERO  = 2'd0;
    localparam logic [1:0] SYM_ONE   = 2'd1;
    localparam logic [1:0] SYM_MINUS = 2'd2;
    localparam logic [1:0] SYM_POINT = 2'd3;

    localparam logic [31:0] POW3 [0:20] = '{
        32'd1, 32'd3, 32'd9, 32'd27, 32'd81, 32'd243, 32'd729, 32'd2187,
        32'd6561, 32'd19683, 32'd59049, 32'd177147, 32'd531441, 32'd1594323,
        32'd4782969, 32'd14348907, 32'd43046721, 32'd129140163,
        32'd387420489, 32'd1162261467, 32'd3486784401
    };

    typedef struct packed {
        logic signed [31:0] numerator;
        logic [30:0]        denominator;
    } item_t;

    typedef struct packed {
        logic [1:0] symbol;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_DIGIT,
        SEL_POINT
    } sym_sel_t;

    typedef struct packed {
        logic     load;
        logic     conv;
        logic     p_top;
        logic     p_frac;
        logic     p_dec;
        logic     emit;
        sym_sel_t sel;
        logic     last;
    } ctl_cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic n_zero;
        logic den_more;
        logic lead_needed;
        logic point_needed;
        logic p_at_mov;
        logic p_at_fl;
        logic at_limit;
    } ctl_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/btfc_dpath.sv
`default_nettype none

module btfc_dpath
    import btfc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  item_t      item,
    input  ctl_cmd_t   cmd,
    output ctl_stat_t  stat,
    output result_t    result,
    output logic       strobe
);

    localparam int RUN_LIMIT = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;
    localparam logic [CNT_W-1:0] LIMIT_LAST = CNT_W'(RUN_LIMIT - 1);
    localparam logic [DIG_W-1:0] MOV_TOP    = DIG_W'(MOV_MAX);

    logic [31:0]      mag_reg;
    logic             neg_reg;
    logic [30:0]      den_reg;
    logic [1:0]       dig_reg [DIG_DEPTH];
    logic [DIG_W-1:0] n_reg;
    logic [DIG_W-1:0] mov_reg;
    logic [DIG_W-1:0] fl_reg;
    logic             seen_reg;
    logic [DIG_W-1:0] p_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       symbol_reg;
    logic             last_reg;
    logic             strobe_reg;

    logic [31:0] neg_num;
    logic [31:0] y;
    logic [63:0] prod;
    logic [30:0] q;
    logic [1:0]  q3;
    logic [1:0]  ymod;
    logic [1:0]  code;
    logic [1:0]  code_s;
    logic [DIG_W-1:0] mov_inc;
    logic [1:0]  rd_dig;
    logic [1:0]  sym_next;

    assign neg_num = 32'd0 - item.numerator;

    // floor((x + 1) / 3) is the next magnitude for every remainder
    assign y    = mag_reg + 32'd1;
    assign prod = y * RECIP3;
    assign q    = prod[63:33];
    assign q3   = {q[0], 1'b0} + q[1:0];
    assign ymod = y[1:0] - q3;

    always_comb
    begin
        case (ymod)
            2'd0:    code = SYM_MINUS;
            2'd1:    code = SYM_ZERO;
            default: code = SYM_ONE;
        endcase
        if (neg_reg && code != SYM_ZERO)
            code_s = (code == SYM_ONE) ? SYM_MINUS : SYM_ONE;
        else
            code_s = code;
    end

    assign mov_inc = mov_reg + DIG_W'(1);

    assign stat.mag_zero     = (mag_reg == 32'd0);
    assign stat.n_zero       = (n_reg == '0);
    // the quotient after mov divisions is still above one: den >= 2 * 3^mov
    assign stat.den_more     = (mov_reg <= MOV_TOP) &&
                               ({1'b0, den_reg} >= {POW3[mov_reg][30:0], 1'b0});
    assign stat.lead_needed  = (mov_reg >= n_reg);
    assign stat.point_needed = (mov_reg > fl_reg);
    assign stat.p_at_mov     = (p_reg == mov_reg);
    assign stat.p_at_fl      = (p_reg == fl_reg);
    assign stat.at_limit     = (cnt_reg == LIMIT_LAST);

    // Positions above the top digit read as zero
    assign rd_dig = (p_reg < n_reg) ? dig_reg[p_reg] : SYM_ZERO;

    always_comb
    begin
        case (cmd.sel)
            SEL_DIGIT: sym_next = rd_dig;
            SEL_POINT: sym_next = SYM_POINT;
            default:   sym_next = SYM_ZERO;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg  <= item.numerator[31] ? neg_num : item.numerator;
            neg_reg  <= item.numerator[31];
            den_reg  <= item.denominator;
            n_reg    <= '0;
            mov_reg  <= '0;
            fl_reg   <= '0;
            seen_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.conv)
            begin
                if (mag_reg != 32'd0)
                begin
                    mag_reg        <= {1'b0, q};
                    dig_reg[n_reg] <= code_s;
                    n_reg          <= n_reg + DIG_W'(1);
                    if (!seen_reg && code_s != SYM_ZERO)
                    begin
                        fl_reg   <= n_reg;
                        seen_reg <= 1'b1;
                    end
                end
                if (stat.den_more)
                    mov_reg <= mov_inc;
            end
            if (cmd.emit)
                cnt_reg <= cnt_reg + CNT_W'(1);
        end

        if (cmd.p_top)
            p_reg <= n_reg - DIG_W'(1);
        else if (cmd.p_frac)
            p_reg <= mov_reg - DIG_W'(1);
        else if (cmd.p_dec)
            p_reg <= p_reg - DIG_W'(1);

        if (cmd.emit)
        begin
            symbol_reg <= sym_next;
            last_reg   <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit;
    end

    assign result.symbol = symbol_reg;
    assign result.last   = last_reg;
    assign strobe        = strobe_reg;

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |=> !strobe_reg)
        else $error("beat follows the last beat of a run");

    a_mov_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv && !cmd.load |=> mov_reg <= MOV_TOP)
        else $error("point shift beyond range");

endmodule

`default_nettype wire

FILE: rtl/core/btfc_ctrl.sv
`default_nettype none

module btfc_ctrl
    import btfc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    input  ctl_stat_t  stat,
    output ctl_cmd_t   cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_LEAD,
        S_INT,
        S_POINT,
        S_FRAC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (stat.mag_zero && (stat.n_zero || !stat.den_more))
                begin
                    if (stat.n_zero)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (stat.lead_needed)
                        state_next = S_LEAD;
                    else
                    begin
                        cmd.p_top  = 1'b1;
                        state_next = S_INT;
                    end
                end
                else
                    cmd.conv = 1'b1;
            end
            S_LEAD:
            begin
                // integer part empty: a point follows unless the symbol limit ends the run here
                cmd.emit   = 1'b1;
                cmd.last   = stat.at_limit;
                state_next = stat.at_limit ? S_IDLE : S_POINT;
            end
            S_INT:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = SEL_DIGIT;
                cmd.last = (stat.p_at_mov && !stat.point_needed) || stat.at_limit;
                if (cmd.last)
                    state_next = S_IDLE;
                else if (stat.p_at_mov)
                    state_next = S_POINT;
                else
                    cmd.p_dec = 1'b1;
            end
            S_POINT:
            begin
                cmd.emit   = 1'b1;
                cmd.sel    = SEL_POINT;
                cmd.p_frac = 1'b1;
                cmd.last   = stat.at_limit;
                state_next = stat.at_limit ? S_IDLE : S_FRAC;
            end
            S_FRAC:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = SEL_DIGIT;
                cmd.last = stat.p_at_fl || stat.at_limit;
                if (cmd.last)
                    state_next = S_IDLE;
                else
                    cmd.p_dec = 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

    a_limit_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && stat.at_limit |-> cmd.last)
        else $error("run passes its symbol limit");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy_reg && !cmd.emit)
        else $error("beat loaded while busy");

endmodule

`default_nettype wire

FILE: rtl/core/balanced_ternary_fraction_converter_top.sv
`default_nettype none

// Channel   Ports                          Beat taken when
// input     start, busy, item              start && !busy at a rising edge
// result    strobe, result                 strobe high, one cycle, no stall
//
// After the load edge, busy holds while the magnitude gives one balanced
// ternary digit and the point shift one step per cycle, until the longer
// run ends (up to 21 steps, each digit a divide-by-three by the reciprocal
// multiplier), then while the read-out is set up and one symbol per cycle
// is emitted (up to 22). A zero numerator goes straight to its one symbol.
// Reset clears the controller and the result strobe; busy drops in the cycle
// after the last symbol is issued, so a new item may load while it is shown.
// The receiver cannot stall: every result beat is on the ports for one cycle.

module balanced_ternary_fraction_converter_top
    import btfc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire      clk,
    input  wire      rst_n,
    input  wire      start,
    output logic     busy,
    input  item_t    item,
    output logic     strobe,
    output result_t  result
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    btfc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    btfc_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

endmodule

`default_nettype wire

FILE: tb/sv/balanced_ternary_fraction_converter_top_test.sv
module balanced_ternary_fraction_converter_top_test;
    import btfc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS  = 450;
    localparam int CALM_ITEMS    = 60;
    localparam int BURST_ITEMS   = 40;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    strobe;
    result_t result;

    result_t pending_symbols [$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      idling_on   = 1'b1;

    balanced_ternary_fraction_converter_top DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Work out the symbol run for one item and queue it behind earlier runs
    function automatic void predict_symbols(input item_t it);
        logic [32:0] mag;
        logic [32:0] rem;
        logic [30:0] den;
        logic [1:0]  dig [32];
        logic [1:0]  code;
        logic        neg;
        int          n;
        int          shift;
        int          top;
        int          fl;
        int          p;
        int          limit;
        result_t     run [$];
        result_t     r;

        neg = it.numerator[31];
        mag = {1'b0, it.numerator};
        if (neg)
            mag = (~mag + 33'd1) & 33'h0_FFFF_FFFF;
        for (int i = 0; i < 32; i++)
            dig[i] = SYM_ZERO;
        n = 0;
        r.last = 1'b0;

        if (mag == 33'd0)
        begin
            r.symbol = SYM_ZERO;
            run.push_back(r);
        end
        else
        begin
            while (mag != 33'd0 && n < 32)
            begin
                rem = mag % 33'd3;
                if (rem == 33'd2)
                begin
                    code = SYM_MINUS;
                    mag  = (mag + 33'd1) / 33'd3;
                end
                else
                begin
                    code = (rem == 33'd1) ? SYM_ONE : SYM_ZERO;
                    mag  = mag / 33'd3;
                end
                // negate the digit for a negative numerator
                if (neg && code != SYM_ZERO)
                    code = (code == SYM_ONE) ? SYM_MINUS : SYM_ONE;
                dig[n] = code;
                n++;
            end

            den   = it.denominator;
            shift = 0;
            while (den > 31'd1)
            begin
                den = den / 31'd3;
                shift++;
            end

            top = n - 1;
            fl  = 0;
            while (fl < top && dig[fl] == SYM_ZERO)
                fl++;

            if (shift > top)
            begin
                r.symbol = SYM_ZERO;
                run.push_back(r);
            end
            for (p = top; p >= shift; p--)
            begin
                r.symbol = dig[p];
                run.push_back(r);
            end
            if (shift > fl)
            begin
                r.symbol = SYM_POINT;
                run.push_back(r);
            end
            // positions above the top digit read as zero
            for (p = shift - 1; p >= fl; p--)
            begin
                r.symbol = (p < n) ? dig[p] : SYM_ZERO;
                run.push_back(r);
            end
        end

        limit = (MAX_DIGITS_DEF < RESULT_CAP) ? MAX_DIGITS_DEF : RESULT_CAP;
        if (limit < 1)
            limit = 1;
        while (run.size() > limit)
            void'(run.pop_back());
        run[run.size() - 1].last = 1'b1;
        foreach (run[k])
            pending_symbols.push_back(run[k]);
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && strobe)
        begin
            if (pending_symbols.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected beat, expected none, actual symbol %0d last %0b",
                         $time, result.symbol, result.last);
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (result.symbol !== want.symbol)
                begin
                    error_count++;
                    $display("%0t: symbol mismatch, expected %0d, actual %0d",
                             $time, want.symbol, result.symbol);
                end
                if (result.last !== want.last)
                begin
                    error_count++;
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, result.last);
                end
            end
        end
    end

    // Leaves start high on return so a following beat needs no toggle
    task automatic send_item(input logic signed [31:0] num, input logic [30:0] den);
        item_t it;
        it.numerator   = num;
        it.denominator = den;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        predict_symbols(it);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_idle();
        if (idling_on && $urandom_range(0, 2) == 0)
            hold_off($urandom_range(1, 17));
    endtask

    task automatic send_and_idle(input logic signed [31:0] num, input logic [30:0] den);
        send_item(num, den);
        maybe_idle();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_zero_numerator();
        send_and_idle(32'sd0, 31'd1);
        send_and_idle(32'sd0, 31'd0);
        send_and_idle(32'sd0, POW3[19][30:0]);
        send_and_idle(32'sd0, 31'h7FFF_FFFF);
    endtask

    task automatic test_denominator_edges();
        send_and_idle(32'sd5, 31'd0);
        send_and_idle(32'sd5, 31'd1);
        send_and_idle(32'sd5, 31'd2);
        send_and_idle(32'sd7, 31'd3);
        send_and_idle(-32'sd13, 31'd10);
        send_and_idle(32'sd100, 31'h7FFF_FFFF);
        send_and_idle(-32'sd1000, 31'h5555_5555);
    endtask

    task automatic test_numerator_extremes();
        send_and_idle(32'sh7FFF_FFFF, 31'd1);
        send_and_idle(-32'sh7FFF_FFFF, 31'd1);
        send_and_idle(32'sh8000_0000, 31'd1);
        send_and_idle(32'sh8000_0000, POW3[19][30:0]);
        send_and_idle(32'sh7FFF_FFFF, POW3[19][30:0]);
        send_and_idle(32'sd1, 31'd1);
        send_and_idle(-32'sd1, 31'd1);
    endtask

    task automatic test_point_placement();
        // fraction at least as wide as the digits; the first two pad zeros after the point
        send_and_idle(32'sd1, POW3[19][30:0]);
        send_and_idle(-32'sd1, POW3[10][30:0]);
        send_and_idle(32'sd9, 31'd27);
        // trailing fractional zeros dropped, the point with them when none remain; the last item keeps its fraction
        send_and_idle(32'sd27, 31'd3);
        send_and_idle(-32'sd486, 31'd81);
        send_and_idle(32'sd40, 31'd9);
    endtask

    function automatic logic signed [31:0] random_numerator();
        logic signed [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 80) - 40;
            1:       v = $urandom_range(0, 1) ? POW3[$urandom_range(0, 19)]
                                              : -POW3[$urandom_range(0, 19)];
            2:       v = ($urandom_range(0, 9) == 0) ? 32'sh8000_0000 : 32'sd0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [30:0] random_denominator();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 10);
            default: v = POW3[$urandom_range(0, 19)];
        endcase
        return v[30:0];
    endfunction

    task automatic test_random_items();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // switch idling on and off in bursts, none at all near the end
            if (i % BURST_ITEMS == 0)
                idling_on = ($urandom_range(0, 3) != 0);
            if (i >= RANDOM_ITEMS - CALM_ITEMS)
                idling_on = 1'b0;
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            send_and_idle(random_numerator(), random_denominator());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_numerator();
        test_denominator_edges();
        test_numerator_extremes();
        test_point_placement();
        wait_drained();
        test_random_items();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_symbols.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
